>>> hw/rtl/nssc_pkg.sv
// Shared constants, widths and the sequencer control word for the slew convolver.
package nssc_pkg;

    // Default sizing of the block.
    localparam int MAX_TAPS_DEF = 256;
    localparam int AXES_DEF     = 3;

    // Field widths.
    localparam int SAMPLE_W = 18;
    localparam int DIFF_W   = 19;
    localparam int KERN_W   = 24;
    localparam int GAIN_W   = 24;
    localparam int PNS_W    = 32;
    localparam int IDX_W    = 16;
    localparam int LAG_W    = 8;

    // Product of one kernel word and one difference, signed.
    localparam int PROD_W = KERN_W + 1 + DIFF_W;
    // Width of the scaling multiplier operand and of its product.
    localparam int MUL_A_W = 32;
    localparam int MUL_P_W = MUL_A_W + GAIN_W;
    // Rounded scaled magnitude.
    localparam int RES_W = MUL_P_W + 1;

    // Output gain after reset is 1.0 in Q8.16.
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    // Action codes.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Strobes from the sequencer to every lane.
    typedef struct packed {
        logic prev_ld;
        logic hist_wr;
        logic acc_clr;
        logic issue;
        logic prod_en;
        logic acc_en;
        logic sc_mag;
        logic sc_mlo;
        logic sc_mhi;
        logic sc_sum;
        logic sc_sat;
    } nssc_ctl_t;

endpackage

>>> hw/rtl/nssc_lane.sv
// One axis lane: difference history memory, multiply-accumulate and output scaling.
module nssc_lane #(
    parameter int MAX_TAPS = nssc_pkg::MAX_TAPS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  nssc_pkg::nssc_ctl_t                  ctl,
    input  logic signed [nssc_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [$clog2(MAX_TAPS)-1:0]          wr_addr,
    input  logic [$clog2(MAX_TAPS)-1:0]          rd_addr,
    input  logic [nssc_pkg::KERN_W-1:0]          kern,
    input  logic [nssc_pkg::GAIN_W-1:0]          gain,
    output logic signed [nssc_pkg::PNS_W-1:0]    pns,
    output logic                                 clip
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int ACC_W = nssc_pkg::PROD_W - 1 + AW;

    logic signed [nssc_pkg::SAMPLE_W-1:0] prev_reg;
    logic signed [nssc_pkg::DIFF_W-1:0]   diff;
    logic signed [nssc_pkg::DIFF_W-1:0]   hmem [MAX_TAPS];
    logic signed [nssc_pkg::DIFF_W-1:0]   hist_q_reg;
    logic signed [nssc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic                                 neg_reg;
    logic [ACC_W-1:0]                     mag_reg;
    logic [nssc_pkg::MUL_A_W-1:0]         mul_a;
    logic [nssc_pkg::MUL_P_W-1:0]         mul_p;
    logic [nssc_pkg::MUL_P_W-1:0]         plo_reg;
    logic [nssc_pkg::MUL_P_W-1:0]         phi_reg;
    logic [nssc_pkg::RES_W-1:0]           plo_rnd;
    logic [nssc_pkg::RES_W-1:0]           r_reg;
    logic                                 sat;
    logic signed [nssc_pkg::PNS_W-1:0]    sat_val;
    logic signed [nssc_pkg::PNS_W-1:0]    pns_reg;
    logic                                 clip_reg;

    // New first difference of this axis.
    assign diff = nssc_pkg::DIFF_W'(s_sample) - nssc_pkg::DIFF_W'(prev_reg);

    // Previous sample, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (ctl.prev_ld) begin
            prev_reg <= s_sample;
        end
    end

    // Circular history of differences, newest at the write pointer.
    always_ff @(posedge aclk) begin
        if (ctl.hist_wr) begin
            hmem[wr_addr] <= diff;
        end
        if (ctl.issue) begin
            hist_q_reg <= hmem[rd_addr];
        end
    end

    // Multiply one tap, then accumulate.
    always_ff @(posedge aclk) begin
        if (ctl.prod_en) begin
            prod_reg <= $signed({1'b0, kern}) * hist_q_reg;
        end
        if (ctl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // The scaling multiplier is shared by the low and high halves of the magnitude.
    assign mul_a = ctl.sc_mhi ? nssc_pkg::MUL_A_W'(mag_reg[ACC_W-1:32]) : mag_reg[31:0];
    assign mul_p = mul_a * nssc_pkg::MUL_P_W'(gain);
    assign plo_rnd = (nssc_pkg::RES_W'(plo_reg) + nssc_pkg::RES_W'(33'h8000_0000)) >> 32;

    // Magnitude, partial products and rounded sum.
    always_ff @(posedge aclk) begin
        if (ctl.sc_mag) begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
        end
        if (ctl.sc_mlo) begin
            plo_reg <= mul_p;
        end
        if (ctl.sc_mhi) begin
            phi_reg <= mul_p;
        end
        if (ctl.sc_sum) begin
            r_reg <= nssc_pkg::RES_W'(phi_reg) + plo_rnd;
        end
    end

    // Saturate to 32 bits and restore the sign.
    always_comb begin
        if (!neg_reg) begin
            sat     = r_reg > nssc_pkg::RES_W'(32'h7FFF_FFFF);
            sat_val = sat ? 32'sh7FFF_FFFF : r_reg[31:0];
        end else begin
            sat     = r_reg > nssc_pkg::RES_W'(32'h8000_0000);
            sat_val = sat ? 32'sh8000_0000 : (~r_reg[31:0] + 32'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sc_sat) begin
            pns_reg  <= sat_val;
            clip_reg <= sat;
        end
    end

    assign pns  = pns_reg;
    assign clip = clip_reg;

endmodule

>>> hw/rtl/nssc_ctrl.sv
// Sequencer: kernel memory, history pointers, tap counter and scaling steps.
module nssc_ctrl #(
    parameter int MAX_TAPS = nssc_pkg::MAX_TAPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [nssc_pkg::LAG_W-1:0]         s_lag_index,
    input  logic [nssc_pkg::KERN_W-1:0]        s_kernel_word,
    input  logic                               s_first_sample,
    input  logic                               out_free,
    output nssc_pkg::nssc_ctl_t                ctl,
    output logic [nssc_pkg::KERN_W-1:0]        kern,
    output logic [$clog2(MAX_TAPS)-1:0]        wr_addr,
    output logic [$clog2(MAX_TAPS)-1:0]        rd_addr,
    output logic                               out_load,
    output logic [nssc_pkg::IDX_W-1:0]         out_index
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int LW = (AW > nssc_pkg::LAG_W) ? AW : nssc_pkg::LAG_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MLO   = 3'd3;
    localparam logic [2:0] ST_MHI   = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_SAT   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [AW-1:0]               wp_reg, wp_next;
    logic [AW-1:0]               rptr_reg, rptr_next;
    logic [TW-1:0]               fill_reg, fill_next;
    logic [TW-1:0]               k_reg, k_next;
    logic [nssc_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic                        v1_reg;
    logic                        v2_reg;
    logic [nssc_pkg::KERN_W-1:0] kmem [MAX_TAPS];
    logic [nssc_pkg::KERN_W-1:0] kern_q_reg;
    logic [LW-1:0]               lag_ext;
    logic                        lag_ok;
    logic                        take;
    logic                        kld;
    logic                        smp;
    logic                        step;

    // Decode of the accepted word.
    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_valid && s_ready;
    assign kld     = take && (s_action == nssc_pkg::ACT_LOAD);
    assign smp     = take && (s_action == nssc_pkg::ACT_SAMPLE);
    assign step    = smp && !s_first_sample;
    assign lag_ext = LW'(s_lag_index);
    assign lag_ok  = (32'(s_lag_index) < MAX_TAPS);

    // Strobes to the lanes.
    always_comb begin
        ctl.prev_ld = smp;
        ctl.hist_wr = step;
        ctl.acc_clr = step;
        ctl.issue   = (state_reg == ST_RUN);
        ctl.prod_en = v1_reg;
        ctl.acc_en  = v2_reg;
        ctl.sc_mag  = (state_reg == ST_DRAIN) && !v1_reg && !v2_reg;
        ctl.sc_mlo  = (state_reg == ST_MLO);
        ctl.sc_mhi  = (state_reg == ST_MHI);
        ctl.sc_sum  = (state_reg == ST_SUM);
        ctl.sc_sat  = (state_reg == ST_SAT);
    end

    assign out_load  = (state_reg == ST_OUT) && out_free;
    assign out_index = cnt_reg;
    assign wr_addr   = wp_reg;
    assign rd_addr   = rptr_reg;
    assign kern      = kern_q_reg;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rptr_next  = rptr_reg;
        fill_next  = fill_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (smp && s_first_sample) begin
                    fill_next = '0;
                    cnt_next  = '0;
                end else if (step) begin
                    fill_next  = (fill_reg == TW'(MAX_TAPS)) ? fill_reg : fill_reg + TW'(1);
                    k_next     = '0;
                    rptr_next  = wp_reg;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if ((k_reg + TW'(1)) == fill_reg) begin
                    wp_next    = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + AW'(1);
                    state_next = ST_DRAIN;
                end else begin
                    k_next    = k_reg + TW'(1);
                    rptr_next = (rptr_reg == '0) ? AW'(MAX_TAPS - 1) : rptr_reg - AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_MLO;
                end
            end
            ST_MLO: state_next = ST_MHI;
            ST_MHI: state_next = ST_SUM;
            ST_SUM: state_next = ST_SAT;
            ST_SAT: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    cnt_next   = cnt_reg + nssc_pkg::IDX_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rptr_reg  <= '0;
            fill_reg  <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rptr_reg  <= rptr_next;
            fill_reg  <= fill_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            v1_reg    <= ctl.issue;
            v2_reg    <= v1_reg;
        end
    end

    // Kernel memory: written by load words, read once per tap.
    always_ff @(posedge aclk) begin
        if (kld && lag_ok) begin
            kmem[lag_ext[AW-1:0]] <= s_kernel_word;
        end
        if (ctl.issue) begin
            kern_q_reg <= kmem[k_reg[AW-1:0]];
        end
    end

    // The fill count never passes the history depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= TW'(MAX_TAPS))
        else $error("history fill count beyond depth");

    // Taps are only issued for lags that hold differences of this waveform.
    a_tap_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (k_reg < fill_reg))
        else $error("tap issued beyond history fill");

    // At most one scaling step at a time.
    a_scale_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.sc_mag, ctl.sc_mlo, ctl.sc_mhi, ctl.sc_sum, ctl.sc_sat}))
        else $error("overlapping scaling steps");

    // Scaling starts only once the multiply-accumulate pipeline is empty.
    a_mag_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.sc_mag |-> ($past(state_reg) != ST_RUN))
        else $error("scaling started with taps in flight");

endmodule

>>> hw/rtl/nerve_stim_slew_convolver.sv
// Top level of the slew convolver: configuration, lanes per axis and the result merge.
//
// Usage. Words enter on the s_ channel (valid/ready). A word with action 0
// writes one kernel lag and gives no result. A waveform sample with
// first_sample set restarts the difference history and gives no result.
// Every other sample gives one result on the m_ channel (valid/ready): the
// per-axis filtered values, the position in the waveform and a clip flag.
// The gain register must be written by the user over the cfg_ channel only while
// the block is idle; the block itself does not enforce it. A kernel word or a first
// sample is taken while idle and leaves the block ready. A filtering sample keeps
// the block busy until its result is in the output register; its run grows with N,
// the number of differences held for the current waveform (at most MAX_TAPS), since
// each history memory has a single tap read port and one multiply-accumulate per lane.
// The axes run in parallel lanes, so AXES does not change the timing.
// Reset clears the previous samples, the history fill count, the position
// counter and sets the gain to 1.0; kernel words must be loaded again.
// A stalled receiver holds the result in the output register; the block
// still takes the next word, and waits before overwriting the result.
module nerve_stim_slew_convolver #(
    parameter int MAX_TAPS = nssc_pkg::MAX_TAPS_DEF,
    parameter int AXES     = nssc_pkg::AXES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [nssc_pkg::LAG_W-1:0]           s_lag_index,
    input  logic [nssc_pkg::KERN_W-1:0]          s_kernel_word,
    input  logic                                 s_first_sample,
    input  logic signed [nssc_pkg::SAMPLE_W-1:0] s_sample_x,
    input  logic signed [nssc_pkg::SAMPLE_W-1:0] s_sample_y,
    input  logic signed [nssc_pkg::SAMPLE_W-1:0] s_sample_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [nssc_pkg::PNS_W-1:0]    m_pns_x,
    output logic signed [nssc_pkg::PNS_W-1:0]    m_pns_y,
    output logic signed [nssc_pkg::PNS_W-1:0]    m_pns_z,
    output logic [nssc_pkg::IDX_W-1:0]           m_out_index,
    output logic                                 m_clipped,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nssc_pkg::GAIN_W-1:0]          cfg_data
);

    localparam int AW = $clog2(MAX_TAPS);

    nssc_pkg::nssc_ctl_t                  ctl;
    logic [nssc_pkg::KERN_W-1:0]          kern;
    logic [AW-1:0]                        wr_addr;
    logic [AW-1:0]                        rd_addr;
    logic                                 out_load;
    logic                                 out_free;
    logic [nssc_pkg::IDX_W-1:0]           out_index;
    logic [nssc_pkg::GAIN_W-1:0]          gain_reg;
    logic signed [nssc_pkg::SAMPLE_W-1:0] samp [3];
    logic signed [nssc_pkg::PNS_W-1:0]    lane_pns [AXES];
    logic                                 lane_clip [AXES];
    logic signed [nssc_pkg::PNS_W-1:0]    pad_pns [3];
    logic [2:0]                           pad_clip;
    logic                                 m_valid_reg;
    logic signed [nssc_pkg::PNS_W-1:0]    pns_x_reg;
    logic signed [nssc_pkg::PNS_W-1:0]    pns_y_reg;
    logic signed [nssc_pkg::PNS_W-1:0]    pns_z_reg;
    logic [nssc_pkg::IDX_W-1:0]           out_index_reg;
    logic                                 clipped_reg;

    // Gain register; the user must only write while the block is idle; not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= nssc_pkg::GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            gain_reg <= cfg_data;
        end
    end

    assign samp[0] = s_sample_x;
    assign samp[1] = s_sample_y;
    assign samp[2] = s_sample_z;

    // Output register may take a new result.
    assign out_free = !m_valid_reg || m_ready;

    nssc_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_lag_index    (s_lag_index),
        .s_kernel_word  (s_kernel_word),
        .s_first_sample (s_first_sample),
        .out_free       (out_free),
        .ctl            (ctl),
        .kern           (kern),
        .wr_addr        (wr_addr),
        .rd_addr        (rd_addr),
        .out_load       (out_load),
        .out_index      (out_index)
    );

    // One lane per axis, all driven by the same strobes and kernel word.
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        nssc_lane #(
            .MAX_TAPS (MAX_TAPS)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .s_sample (samp[g]),
            .wr_addr  (wr_addr),
            .rd_addr  (rd_addr),
            .kern     (kern),
            .gain     (gain_reg),
            .pns      (lane_pns[g]),
            .clip     (lane_clip[g])
        );
    end

    // Unused axes read as zero and never clip.
    for (genvar g = 0; g < 3; g++) begin : g_pad
        if (g < AXES) begin : g_used
            assign pad_pns[g]  = lane_pns[g];
            assign pad_clip[g] = lane_clip[g];
        end else begin : g_unused
            assign pad_pns[g]  = '0;
            assign pad_clip[g] = 1'b0;
        end
    end

    // Merge stage: result handshake flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Merge stage: result payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            pns_x_reg     <= pad_pns[0];
            pns_y_reg     <= pad_pns[1];
            pns_z_reg     <= pad_pns[2];
            out_index_reg <= out_index;
            clipped_reg   <= |pad_clip;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pns_x     = pns_x_reg;
    assign m_pns_y     = pns_y_reg;
    assign m_pns_z     = pns_z_reg;
    assign m_out_index = out_index_reg;
    assign m_clipped   = clipped_reg;

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("result overwritten while stalled");

    // No word is taken while a result is being computed for the previous one.
    a_busy_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.issue || ctl.sc_sat) |-> !s_ready)
        else $error("input taken during computation");

    // Clip flag is set only when some axis sits at a rail.
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && clipped_reg) |->
            (pns_x_reg == 32'sh7FFF_FFFF || pns_x_reg == 32'sh8000_0000 ||
             pns_y_reg == 32'sh7FFF_FFFF || pns_y_reg == 32'sh8000_0000 ||
             pns_z_reg == 32'sh7FFF_FFFF || pns_z_reg == 32'sh8000_0000))
        else $error("clip flag without a saturated axis");

endmodule
